@@ sv/bca_pkg.sv @@
// Package: shared types and constants for the cluster allocator.
package bca_pkg;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE     = 2'd2;

   localparam int SIZE_W  = 13;
   localparam int COUNT_W = 11;
   localparam int ADDR_W  = 32;
   localparam int STAT_W  = 2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

   localparam logic [SIZE_W-1:0]  SIZE_RST  = 13'd16;
   localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_CLEAR  = 11'b00000000010,
      S_DIV    = 11'b00000000100,
      S_SCAN   = 11'b00000001000,
      S_SCANW  = 11'b00000010000,
      S_MUL    = 11'b00000100000,
      S_MARK   = 11'b00001000000,
      S_FREE   = 11'b00010000000,
      S_FREEW  = 11'b00100000000,
      S_RESP   = 11'b01000000000,
      S_MARKW  = 11'b10000000000
   } state_type;

endpackage

@@ sv/bca_if.sv @@
// Interfaces: valid/ready channels for requests and responses.
interface bca_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [bca_pkg::ADDR_W-1:0] request_bytes;
   logic [bca_pkg::ADDR_W-1:0] free_address;
   modport source (output valid, func, request_bytes, free_address, input ready);
   modport sink   (input valid, func, request_bytes, free_address, output ready);
endinterface

interface bca_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bca_pkg::STAT_W-1:0] status;
   logic [bca_pkg::ADDR_W-1:0] block_address;
   modport source (output valid, status, block_address, input ready);
   modport sink   (input valid, status, block_address, output ready);
endinterface

@@ sv/bitmap_cluster_allocator.sv @@
// Top level: first-fit bitmap cluster allocator.
// After reset a clearing pass over every bank of both maps runs before any request.
// Allocate: division, cluster scan, multiply, marking bank by bank, then out.
// Free: division, then a read and write per bank touched by the chain walk, then out.
// One request at a time; the response register frees the input once read.
// Reset is synchronous, active high; maps read as all zeros after the clearing pass.
module bitmap_cluster_allocator #(
   parameter int MAX_CLUSTERS = 1024,
   parameter int BANK_BITS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   bca_req_if.sink                       req,
   bca_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [bca_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bca_pkg::ADDR_W-1:0]    csr_wdata
);
   localparam int NB   = (MAX_CLUSTERS + BANK_BITS - 1) / BANK_BITS;
   localparam int BA_W = (NB > 1) ? $clog2(NB) : 1;
   localparam int BP_W = $clog2(BANK_BITS);
   localparam int ID_W = $clog2(MAX_CLUSTERS) + 1;
   localparam int MAXID = MAX_CLUSTERS;

   logic [bca_pkg::SIZE_W-1:0]  csize_ff;
   logic [bca_pkg::COUNT_W-1:0] ccount_ff;
   logic [bca_pkg::ADDR_W-1:0]  hbase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csize_ff  <= bca_pkg::SIZE_RST;
         ccount_ff <= bca_pkg::COUNT_RST;
         hbase_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bca_pkg::CSR_CLUSTER_SIZE:  csize_ff  <= csr_wdata[bca_pkg::SIZE_W-1:0];
            bca_pkg::CSR_CLUSTER_COUNT: ccount_ff <= csr_wdata[bca_pkg::COUNT_W-1:0];
            bca_pkg::CSR_HEAP_BASE:     hbase_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [bca_pkg::SIZE_W-1:0] cs_eff;
   logic [ID_W:0]              cnt_eff;
   assign cs_eff  = (csize_ff == '0) ? bca_pkg::SIZE_W'(1) : csize_ff;
   assign cnt_eff = ({{(ID_W+1){1'b0}}, ccount_ff} > (ID_W+1+bca_pkg::COUNT_W)'(MAXID))
                    ? (ID_W+1)'(MAXID) : (ID_W+1)'(ccount_ff);

   bca_pkg::state_type st_ff, st_in;
   logic                       func_ff, func_in;
   logic [bca_pkg::ADDR_W-1:0] arg_ff, arg_in;
   logic [bca_pkg::ADDR_W-1:0] q_ff, q_in;
   logic [ID_W:0]              idx_ff, idx_in;
   logic [ID_W:0]              run_ff, run_in;
   logic [ID_W:0]              start_ff, start_in;
   logic [ID_W:0]              end_ff, end_in;
   logic [BA_W-1:0]            clr_ff, clr_in;
   logic                       rv_ff, rv_in;
   logic [bca_pkg::STAT_W-1:0] rst_ff, rst_in;
   logic [bca_pkg::ADDR_W-1:0] radr_ff, radr_in;
   logic [bca_pkg::ADDR_W-1:0] prod_ff, prod_in;

   logic                       div_start, div_done;
   logic [bca_pkg::ADDR_W-1:0] div_q;

   bca_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(arg_in),
      .divisor(cs_eff), .done(div_done), .quotient(div_q)
   );

   logic                 m_we;
   logic [BA_W-1:0]      m_addr;
   logic [BANK_BITS-1:0] u_wd, c_wd, u_rd, c_rd;

   bca_ram #(.WIDTH(BANK_BITS), .DEPTH(NB)) u_use (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(u_wd), .rdata(u_rd));
   bca_ram #(.WIDTH(BANK_BITS), .DEPTH(NB)) u_chn (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(c_wd), .rdata(c_rd));

   logic [BA_W-1:0] ibank;
   logic [BP_W-1:0] ipos;
   assign ibank = BA_W'(idx_ff / BANK_BITS);
   assign ipos  = BP_W'(idx_ff % BANK_BITS);

   assign req.ready     = (st_ff == bca_pkg::S_IDLE) && !rv_ff;
   assign rsp.valid     = rv_ff;
   assign rsp.status    = rst_ff;
   assign rsp.block_address = radr_ff;

   logic [BANK_BITS-1:0] mask;
   logic                 inrun;

   always_comb begin
      st_in = st_ff; func_in = func_ff; arg_in = arg_ff; q_in = q_ff;
      idx_in = idx_ff; run_in = run_ff; start_in = start_ff; end_in = end_ff;
      clr_in = clr_ff; rv_in = rv_ff; rst_in = rst_ff; radr_in = radr_ff;
      prod_in = prod_ff;
      div_start = 1'b0; m_we = 1'b0; m_addr = ibank;
      u_wd = u_rd; c_wd = c_rd; mask = '0; inrun = 1'b0;
      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end
      unique case (st_ff)
         bca_pkg::S_CLEAR: begin
            m_we = 1'b1; m_addr = clr_ff; u_wd = '0; c_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BA_W'(NB - 1)) begin
               st_in = bca_pkg::S_IDLE;
            end
         end
         bca_pkg::S_IDLE: begin
            if (req.valid && req.ready) begin
               func_in = req.func;
               if (req.func == bca_pkg::FUNC_ALLOC) begin
                  arg_in = req.request_bytes - 1'b1;
                  if (req.request_bytes == '0) begin
                     rst_in = bca_pkg::ST_NOSPACE; radr_in = '0;
                     st_in = bca_pkg::S_RESP;
                  end else begin
                     st_in = bca_pkg::S_DIV;
                  end
               end else begin
                  arg_in = req.free_address - hbase_ff;
                  st_in = bca_pkg::S_DIV;
               end
               div_start = (st_in == bca_pkg::S_DIV);
            end
         end
         bca_pkg::S_DIV: begin
            if (div_done) begin
               q_in = div_q;
               idx_in = '0; run_in = '0;
               if (func_ff == bca_pkg::FUNC_ALLOC) begin
                  st_in = bca_pkg::S_SCAN;
               end else if (div_q >= bca_pkg::ADDR_W'(cnt_eff)) begin
                  rst_in = bca_pkg::ST_RANGE; radr_in = '0;
                  st_in = bca_pkg::S_RESP;
               end else begin
                  idx_in = (ID_W+1)'(div_q);
                  st_in = bca_pkg::S_FREE;
               end
            end
         end
         bca_pkg::S_SCAN: begin
            // qty = q+1; q can exceed count, so test with full width
            if (idx_ff >= cnt_eff) begin
               rst_in = bca_pkg::ST_NOSPACE; radr_in = '0;
               st_in = bca_pkg::S_RESP;
            end else begin
               st_in = bca_pkg::S_SCANW;
            end
         end
         bca_pkg::S_SCANW: begin
            if (u_rd[ipos]) begin
               run_in = '0;
               idx_in = idx_ff + 1'b1;
               st_in = bca_pkg::S_SCAN;
            end else if ({{(bca_pkg::ADDR_W-ID_W-1){1'b0}}, run_ff} == q_ff) begin
               start_in = idx_ff - run_ff;
               end_in = idx_ff;
               idx_in = idx_ff - run_ff;
               st_in = bca_pkg::S_MUL;
            end else begin
               run_in = run_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               st_in = bca_pkg::S_SCAN;
            end
         end
         bca_pkg::S_MUL: begin
            prod_in = bca_pkg::ADDR_W'(start_ff) * bca_pkg::ADDR_W'(cs_eff);
            st_in = bca_pkg::S_MARK;
         end
         bca_pkg::S_MARK: begin
            st_in = bca_pkg::S_MARKW;
         end
         bca_pkg::S_MARKW: begin
            for (int b = 0; b < BANK_BITS; b++) begin
               inrun = ((ID_W+1)'(idx_ff / BANK_BITS * BANK_BITS + b) >= start_ff) &&
                       ((ID_W+1)'(idx_ff / BANK_BITS * BANK_BITS + b) <= end_ff);
               mask[b] = inrun;
            end
            m_we = 1'b1;
            u_wd = u_rd | mask;
            c_wd = (c_rd | mask);
            if (end_ff / BANK_BITS == idx_ff / BANK_BITS) begin
               c_wd[BP_W'(end_ff % BANK_BITS)] = 1'b0;
               rst_in = bca_pkg::ST_DONE;
               radr_in = hbase_ff + prod_ff;
               st_in = bca_pkg::S_RESP;
            end else begin
               idx_in = (ID_W+1)'((idx_ff / BANK_BITS + 1'b1) * BANK_BITS);
               st_in = bca_pkg::S_MARK;
            end
         end
         bca_pkg::S_FREE: begin
            st_in = bca_pkg::S_FREEW;
         end
         bca_pkg::S_FREEW: begin
            // clear from idx while chain bits continue, within this bank
            m_we = 1'b1;
            u_wd = u_rd; c_wd = c_rd;
            st_in = bca_pkg::S_RESP;
            rst_in = bca_pkg::ST_DONE; radr_in = '0;
            inrun = 1'b1;
            for (int b = 0; b < BANK_BITS; b++) begin
               if (BP_W'(b) >= ipos && inrun) begin
                  u_wd[b] = 1'b0;
                  if (!c_rd[b]) begin
                     inrun = 1'b0;
                  end
                  c_wd[b] = 1'b0;
               end
            end
            if (inrun && (ibank != BA_W'(NB - 1))) begin
               idx_in = (ID_W+1)'((idx_ff / BANK_BITS + 1'b1) * BANK_BITS);
               st_in = bca_pkg::S_FREE;
            end
         end
         bca_pkg::S_RESP: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               st_in = bca_pkg::S_IDLE;
            end
         end
         default: st_in = bca_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= bca_pkg::S_CLEAR;
         clr_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         rv_ff  <= rv_in;
      end
      func_ff <= func_in; arg_ff <= arg_in; q_ff <= q_in; idx_ff <= idx_in;
      run_ff <= run_in; start_ff <= start_in; end_ff <= end_in;
      rst_ff <= rst_in; radr_ff <= radr_in; prod_ff <= prod_in;
   end
endmodule

@@ sv/bca_ram.sv @@
// Generic single-port RAM with registered read.
module bca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

@@ sv/bca_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bca_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bca_pkg::ADDR_W-1:0] dividend,
   input  logic [bca_pkg::SIZE_W-1:0] divisor,
   output logic                       done,
   output logic [bca_pkg::ADDR_W-1:0] quotient
);
   localparam int CNT_W = $clog2(bca_pkg::ADDR_W + 1);
   logic [bca_pkg::ADDR_W-1:0] q_ff, q_in;
   logic [bca_pkg::SIZE_W:0]   r_ff, r_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [bca_pkg::SIZE_W:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {r_ff[bca_pkg::SIZE_W-1:0], q_ff[bca_pkg::ADDR_W-1]};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = CNT_W'(bca_pkg::ADDR_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[bca_pkg::ADDR_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[bca_pkg::ADDR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done     = busy_ff && (cnt_ff == CNT_W'(1));
   assign quotient = q_in;
endmodule

@@ sv/bca_checker.sv @@
// Checker: port-level properties of the allocator, bound to the top level.
module bca_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bca_pkg::STAT_W-1:0] rsp_status,
   input logic [bca_pkg::ADDR_W-1:0] rsp_block_address
);
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == bca_pkg::ST_DONE || rsp_status == bca_pkg::ST_NOSPACE ||
                     rsp_status == bca_pkg::ST_RANGE))
      else $error("bad status");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bca_pkg::ST_DONE |-> rsp_block_address == '0)
      else $error("address on failure");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_address))
      else $error("response dropped");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken");
endmodule

bind bitmap_cluster_allocator bca_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_block_address(rsp.block_address)
);

@@ bench/tb_bitmap_cluster_allocator.sv @@
// Testbench: allocate/free requests against a bitmap cluster allocator with field checks.
`timescale 1ns / 1ps

module tb_bitmap_cluster_allocator;

   localparam int NCL = 1024;
   localparam longint LIMIT = 64'd40_000_000;

   typedef struct {
      logic        func;
      logic [31:0] request_bytes;
      logic [31:0] free_address;
   } req_type;

   typedef struct {
      logic [bca_pkg::STAT_W-1:0] status;
      logic [31:0]                block_address;
   } rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [bca_pkg::CSR_IDX_W-1:0] csr_index = bca_pkg::CSR_CLUSTER_SIZE;
   logic [31:0] csr_wdata = 0;

   bca_req_if req ();
   bca_rsp_if rsp ();

   bitmap_cluster_allocator DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   bit in_use[NCL];
   bit chained[NCL];
   logic [12:0] m_size = bca_pkg::SIZE_RST;
   logic [10:0] m_count = bca_pkg::COUNT_RST;
   logic [31:0] m_base = 0;
   int errors = 0;
   int send_idle = 17;
   int recv_idle = 70;
   int n_alloc_ok = 0, n_free = 0, n_rsp = 0;
   longint cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout");
         $display("FAIL");
         $finish;
      end
   end

   function automatic rsp_type predict_allocation(req_type r);
      rsp_type o;
      longint cs, cnt, qty, run, start;
      cs = (m_size == 0) ? 1 : m_size;
      cnt = (m_count > NCL) ? NCL : m_count;
      o.status = bca_pkg::ST_NOSPACE;
      o.block_address = 0;
      if (r.func == bca_pkg::FUNC_ALLOC) begin
         if (r.request_bytes != 0) begin
            qty = (longint'(r.request_bytes) - 1) / cs + 1;
            run = 0;
            for (longint i = 0; i < cnt; i++) begin
               if (in_use[i]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == qty) begin
                     start = i + 1 - qty;
                     for (longint k = start; k <= i; k++) begin
                        in_use[k] = 1;
                        chained[k] = (k != i);
                     end
                     o.block_address = m_base + 32'(start * cs);
                     o.status = bca_pkg::ST_DONE;
                     break;
                  end
               end
            end
         end
      end else begin
         logic [31:0] off;
         longint id;
         off = r.free_address - m_base;
         id = longint'(off) / cs;
         if (id >= cnt) begin
            o.status = bca_pkg::ST_RANGE;
         end else begin
            o.status = bca_pkg::ST_DONE;
            in_use[id] = 0;
            while (chained[id]) begin
               chained[id] = 0;
               if (id + 1 >= NCL) break;
               id++;
               in_use[id] = 0;
            end
         end
      end
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         req.func <= bca_pkg::FUNC_ALLOC;
         req.request_bytes <= 0;
         req.free_address <= 0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) begin
            req_type a;
            a.func = req.func;
            a.request_bytes = req.request_bytes;
            a.free_address = req.free_address;
            expected_rsps.push_back(predict_allocation(a));
         end
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_type n;
            n = pending_reqs.pop_front();
            req.valid <= 1;
            req.func <= n.func;
            req.request_bytes <= n.request_bytes;
            req.free_address <= n.free_address;
         end else begin
            req.valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            rsp_type e;
            n_rsp++;
            if (expected_rsps.size() == 0) begin
               $error("unexpected beat: status %0d addr %h", rsp.status, rsp.block_address);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp.status);
                  errors++;
               end
               if (rsp.block_address !== e.block_address) begin
                  $error("block_address expected %h actual %h",
                         e.block_address, rsp.block_address);
                  errors++;
               end
               if (e.status == bca_pkg::ST_DONE && e.block_address != 0) n_alloc_ok++;
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (2200) @(posedge clock);
   endtask

   task automatic write_reg(logic [bca_pkg::CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      if (idx == bca_pkg::CSR_CLUSTER_SIZE) m_size = v[12:0];
      else if (idx == bca_pkg::CSR_CLUSTER_COUNT) m_count = v[10:0];
      else m_base = v;
   endtask

   function automatic void push_alloc(logic [31:0] bytes);
      req_type r;
      r.func = bca_pkg::FUNC_ALLOC;
      r.request_bytes = bytes;
      r.free_address = $urandom;
      pending_reqs.push_back(r);
   endfunction

   function automatic void push_free(logic [31:0] a);
      req_type r;
      r.func = bca_pkg::FUNC_FREE;
      r.request_bytes = $urandom;
      r.free_address = a;
      pending_reqs.push_back(r);
      n_free++;
   endfunction

   // small requests mostly; frees mostly at plausible block starts
   task automatic random_phase(int n);
      longint cs;
      cs = (m_size == 0) ? 1 : m_size;
      for (int i = 0; i < n; i++) begin
         int p;
         p = $urandom_range(99);
         if (p < 50) begin
            if ($urandom_range(19) == 0) push_alloc($urandom);
            else push_alloc($urandom_range(1, 8 * cs));
         end else if (p < 88) begin
            push_free(m_base + 32'($urandom_range(0, 63) * cs));
         end else if (p < 95) begin
            push_free(m_base + $urandom_range(0, 32'(cs * 80)));
         end else begin
            push_free($urandom);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed at reset settings
      push_alloc(0);
      push_alloc(1);
      push_alloc(16);
      push_alloc(17);
      push_alloc(32'hFFFF_FFFF);
      push_alloc(16 * 1024);
      push_free(0);
      push_free(16);
      push_free(20);
      push_free(16 * 1024);
      push_free(32'hFFFF_FFFF);
      push_alloc(16 * 1020);
      push_alloc(16 * 8);
      push_free(16 * 1000);
      drain();

      // zero size, oversized count, wrapped base
      write_reg(bca_pkg::CSR_CLUSTER_SIZE, 0);
      write_reg(bca_pkg::CSR_CLUSTER_COUNT, 32'h7FF);
      write_reg(bca_pkg::CSR_HEAP_BASE, 32'hFFFF_FFF0);
      push_alloc(1);
      push_alloc(40);
      push_free(32'hFFFF_FFF0 + 990);
      push_free(32'hFFFF_FFEF);
      push_alloc(5);
      drain();

      // lowered count, max size
      write_reg(bca_pkg::CSR_CLUSTER_COUNT, 0);
      write_reg(bca_pkg::CSR_CLUSTER_SIZE, 4096);
      push_alloc(1);
      push_free(32'hFFFF_FFF0);
      drain();
      write_reg(bca_pkg::CSR_CLUSTER_SIZE, 13'h1FFF);
      write_reg(bca_pkg::CSR_CLUSTER_COUNT, 3);
      write_reg(bca_pkg::CSR_HEAP_BASE, 32'h8000_0000);
      push_alloc(32'hFFFF_FFFF);
      push_alloc(13'h1FFF * 2);
      push_free(32'h8000_0000);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin send_idle = 70; recv_idle = 17; end
         if (ph == 4) begin send_idle = 0; recv_idle = 0; end
         write_reg(bca_pkg::CSR_CLUSTER_SIZE, (ph % 3 == 0) ? $urandom_range(1, 64)
                                  : (ph % 3 == 1) ? 1 : 4096);
         write_reg(bca_pkg::CSR_CLUSTER_COUNT, (ph == 5) ? 1024 : $urandom_range(20, 200));
         write_reg(bca_pkg::CSR_HEAP_BASE, (ph == 3) ? 32'hFFFF_F000 : $urandom);
         random_phase(290);
         drain();
      end

      $display("covered %0d responses, %0d successful allocations, %0d frees",
               n_rsp, n_alloc_ok, n_free);
      $display("config phases with cluster sizes 0..8191, counts 0..2047, wrapped bases");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ files.f @@
sv/bca_pkg.sv
sv/bca_if.sv
sv/bca_ram.sv
sv/bca_div.sv
sv/bitmap_cluster_allocator.sv
sv/bca_checker.sv
bench/tb_bitmap_cluster_allocator.sv
